// ===== hdl/ner_pkg.sv =====
// constants, register codes and helper functions for the noise excited resonator
`default_nettype none

package ner_pkg;

  // field and datapath widths
  localparam int COEF_W   = 16;
  localparam int SEED_W   = 32;
  localparam int NOISE_W  = 12;
  localparam int HIST_W   = 18;
  localparam int ACC_W    = 32;
  localparam int SAMPLE_W = 16;
  localparam int IDX_W    = 8;

  // xorshift32 shift amounts
  localparam int XS_SHL_A = 13;
  localparam int XS_SHR_B = 17;
  localparam int XS_SHL_C = 5;

  // rounding and Q14 scaling
  localparam int Q_SHIFT = 14;
  localparam logic [ACC_W-1:0] ROUND = ACC_W'(8192);

  // saturation limits
  localparam logic signed [HIST_W-1:0] SAT_MAX = HIST_W'(32767);
  localparam logic signed [HIST_W-1:0] SAT_MIN = -HIST_W'(32768);
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 16'h7fff;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 16'h8000;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_COEF_A = 8'd0;
  localparam logic [IDX_W-1:0] REG_COEF_B = 8'd1;
  localparam logic [IDX_W-1:0] REG_COEF_C = 8'd2;
  localparam logic [IDX_W-1:0] REG_SEED   = 8'd3;

  // generator value after reset
  localparam logic [SEED_W-1:0] SEED_RESET = 32'd1;

  // one step of the xorshift32 generator
  function automatic logic [SEED_W-1:0] xorshift_next(input logic [SEED_W-1:0] s);
    logic [SEED_W-1:0] r;
    r = s;
    r = r ^ (r << XS_SHL_A);
    r = r ^ (r >> XS_SHR_B);
    r = r ^ (r << XS_SHL_C);
    return r;
  endfunction

  // top bits of the state minus 2048: flipping the msb gives the offset value
  function automatic logic signed [NOISE_W-1:0] noise_value(input logic [SEED_W-1:0] s);
    logic [NOISE_W-1:0] t;
    t = s[SEED_W-1 -: NOISE_W];
    return {~t[NOISE_W-1], t[NOISE_W-2:0]};
  endfunction

endpackage

`default_nettype wire

// ===== hdl/noise_excited_resonator.sv =====
// noise excited two-pole resonator with xorshift32 noise source and skid output
`default_nettype none

// One sample is produced for every accepted request, one request per clock
// while request_stall is low. The whole step (generator advance, three
// multiplies, sum, shift and saturation) is done in the accepting cycle from
// the state registers, because each sample feeds the history used by the next
// one; the result lands in a two-entry output buffer, so one more request is
// accepted after the sample side starts stalling. Writing the seed register
// reloads the generator only; history and coefficients are kept. Configuration
// is always ready and should be written while no request is in flight.
module noise_excited_resonator (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // request channel
  input  wire logic                                request_valid,
  output logic                                     request_stall,
  input  wire logic                                last_request,
  // sample channel
  output logic                                     sample_valid,
  input  wire logic                                sample_stall,
  output logic signed [ner_pkg::SAMPLE_W-1:0]      sample,
  output logic                                     last_sample,
  // configuration write channel
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [ner_pkg::IDX_W-1:0]           cfg_index,
  input  wire logic [ner_pkg::SEED_W-1:0]          cfg_data
);

  localparam int PA_W = ner_pkg::COEF_W + ner_pkg::NOISE_W;
  localparam int PB_W = ner_pkg::COEF_W + ner_pkg::HIST_W;

  logic signed [ner_pkg::COEF_W-1:0] coef_a;
  logic signed [ner_pkg::COEF_W-1:0] coef_b;
  logic signed [ner_pkg::COEF_W-1:0] coef_c;
  logic [ner_pkg::SEED_W-1:0]        noise_state;
  logic signed [ner_pkg::HIST_W-1:0] hist_one;
  logic signed [ner_pkg::HIST_W-1:0] hist_two;

  logic [ner_pkg::SEED_W-1:0]          noise_state_next;
  logic signed [ner_pkg::NOISE_W-1:0]  noise_x;
  logic signed [PA_W-1:0]              prod_a;
  logic signed [PB_W-1:0]              prod_b;
  logic signed [PB_W-1:0]              prod_c;
  logic [ner_pkg::ACC_W-1:0]           acc;
  logic signed [ner_pkg::HIST_W-1:0]   hist_one_next;
  logic [ner_pkg::SAMPLE_W-1:0]        sat_sample;

  logic                                main_valid;
  logic [ner_pkg::SAMPLE_W-1:0]        main_sample;
  logic                                main_last;
  logic                                skid_valid;
  logic [ner_pkg::SAMPLE_W-1:0]        skid_sample;
  logic                                skid_last;

  logic req_acc;
  logic cfg_acc;
  logic taken;

  // handshakes
  assign cfg_ready     = 1'b1;
  assign cfg_acc       = cfg_valid & cfg_ready;
  assign request_stall = skid_valid;
  assign req_acc       = request_valid & ~request_stall;
  assign taken         = main_valid & ~sample_stall;

  // generator advance and noise value
  assign noise_state_next = ner_pkg::xorshift_next(noise_state);
  assign noise_x          = ner_pkg::noise_value(noise_state_next);

  // resonator products and wrapped sum
  assign prod_a = coef_a * noise_x;
  assign prod_b = coef_b * hist_one;
  assign prod_c = coef_c * hist_two;
  assign acc = {{(ner_pkg::ACC_W-PA_W){prod_a[PA_W-1]}}, prod_a}
             + prod_b[ner_pkg::ACC_W-1:0]
             + prod_c[ner_pkg::ACC_W-1:0]
             + ner_pkg::ROUND;
  assign hist_one_next = acc[ner_pkg::ACC_W-1 -: ner_pkg::HIST_W];

  // saturation to the sample range
  always_comb begin
    if (hist_one_next > ner_pkg::SAT_MAX) begin
      sat_sample = ner_pkg::SAMPLE_MAX;
    end else if (hist_one_next < ner_pkg::SAT_MIN) begin
      sat_sample = ner_pkg::SAMPLE_MIN;
    end else begin
      sat_sample = hist_one_next[ner_pkg::SAMPLE_W-1:0];
    end
  end

  // configuration registers and generator state
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_a      <= '0;
      coef_b      <= '0;
      coef_c      <= '0;
      noise_state <= ner_pkg::SEED_RESET;
    end else if (cfg_acc) begin
      case (cfg_index)
        ner_pkg::REG_COEF_A: coef_a <= cfg_data[ner_pkg::COEF_W-1:0];
        ner_pkg::REG_COEF_B: coef_b <= cfg_data[ner_pkg::COEF_W-1:0];
        ner_pkg::REG_COEF_C: coef_c <= cfg_data[ner_pkg::COEF_W-1:0];
        ner_pkg::REG_SEED:   noise_state <= cfg_data;
        default: begin
        end
      endcase
    end else if (req_acc) begin
      noise_state <= noise_state_next;
    end
  end

  // history registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hist_one <= '0;
      hist_two <= '0;
    end else if (req_acc) begin
      hist_one <= hist_one_next;
      hist_two <= hist_one;
    end
  end

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (taken) begin
      if (skid_valid) begin
        main_sample <= skid_sample;
        main_last   <= skid_last;
        skid_valid  <= 1'b0;
      end else if (req_acc) begin
        main_sample <= sat_sample;
        main_last   <= last_request;
      end else begin
        main_valid <= 1'b0;
      end
    end else if (req_acc) begin
      if (main_valid) begin
        skid_sample <= sat_sample;
        skid_last   <= last_request;
        skid_valid  <= 1'b1;
      end else begin
        main_sample <= sat_sample;
        main_last   <= last_request;
        main_valid  <= 1'b1;
      end
    end
  end

  assign sample_valid = main_valid;
  assign sample       = main_sample;
  assign last_sample  = main_last;

  // checks
  a_skid_needs_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> main_valid)
    else $error("skid entry held without a main entry");

  a_empty_fill: assert property (@(posedge clk) disable iff (rst)
    req_acc && !main_valid |=> sample_valid && !skid_valid)
    else $error("request into empty buffer did not show a sample");

  a_stall_to_skid: assert property (@(posedge clk) disable iff (rst)
    req_acc && main_valid && sample_stall |=> skid_valid)
    else $error("request during stall was not caught by the skid stage");

  a_hist_shift: assert property (@(posedge clk) disable iff (rst)
    req_acc |=> hist_two == $past(hist_one))
    else $error("history did not shift on a request");

endmodule

`default_nettype wire
